[design/tam_pkg.sv]
// Package: shared types and constants for the triangle aspect mean unit.
`timescale 1ns / 1ps
`default_nettype none
package tam_pkg;
  localparam int COORD_W  = 24;
  localparam int THRESH_W = 48;
  localparam int ASPECT_W = 32;
  localparam int COUNT_W  = 21;
  localparam int DIFF_W   = 25;   // corner difference
  localparam int EDGE_W   = 52;   // squared edge, sum of three
  localparam int CROSS_W  = 50;   // cross product component
  localparam int NSQ_W    = 102;  // squared cross length
  localparam int LEN_W    = 51;   // floor sqrt of NSQ
  localparam logic [ASPECT_W-1:0] ASPECT_MAX = '1;

  localparam logic [1:0] REG_AREA_THRESHOLD = 2'd0;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIFF  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_SQRT  = 9'b000001000,
    ST_ADIV  = 9'b000010000,
    ST_ACC   = 9'b000100000,
    ST_MDIV  = 9'b001000000,
    ST_OUT   = 9'b010000000,
    ST_HOLD  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic               face_valid;
    logic               last_face;
  } tri_t;

  typedef struct packed {
    logic [ASPECT_W-1:0] mean_aspect;
    logic [COUNT_W-1:0]  counted_faces;
  } res_t;
endpackage
`default_nettype wire

[design/tam_if.sv]
// Interfaces: valid/ready channels for triangle items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface tam_tri_if;
  import tam_pkg::*;
  logic valid;
  logic ready;
  tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tam_res_if;
  import tam_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/tam_mul.sv]
// Shared 26x26 signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module tam_mul
  import tam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [25:0] a,
  input  wire logic signed [25:0] b,
  output logic signed [51:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

[design/triangle_aspect_mean_unit.sv]
// Top level: triangle aspect ratio accumulator with iterative sequencer.
// A live triangle keeps the block busy after it is taken through the difference, multiply,
// root, quotient and accumulate states; an item that ends a mesh then passes the mean-divide
// and output states before its result is valid (a skipped last item goes straight to the
// accumulate state), later while the previous result is still stalled. The block takes no
// new item until it is back in idle; the shared multiplier and the bit-serial root and divide
// loops keep it busy. A skipped item that does not end a mesh leaves it idle and ready for the
// next. Synchronous active-low reset clears the sums, the threshold and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module triangle_aspect_mean_unit
  import tam_pkg::*;
#(
  parameter int FACE_COUNT_BITS = 20
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  tam_tri_if.sink           in_ch,
  tam_res_if.source         out_ch,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int SUM_W = FACE_COUNT_BITS + 32;
  localparam int TAL_W = FACE_COUNT_BITS + 1;
  localparam int MIDX_W = $clog2(SUM_W + 1);

  // Configuration register: 64-bit data, register 0 at byte address 0.
  logic [THRESH_W-1:0] thresh_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3:3] == REG_AREA_THRESHOLD[0:0] && cfg_paddr[2:0] == 3'd0)
                      ? {16'd0, thresh_r} : 64'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == {REG_AREA_THRESHOLD[0:0], 3'b000}) begin
      thresh_r <= cfg_pwdata[THRESH_W-1:0];
    end
  end

  state_t state_r;
  tri_t   tri_r;
  logic signed [DIFF_W-1:0] d_r [9];     // u(3), v(3), w(3)
  logic [4:0]  step_r;                   // multiply step index
  logic [6:0]  bit_r;                    // iteration counter
  logic signed [51:0] prod;
  logic signed [25:0] ma, mb;
  logic [EDGE_W-1:0]  e_r [3];
  logic signed [CROSS_W-1:0] n_r [3];
  logic signed [CROSS_W-1:0] part_r;     // first half of a cross term
  logic [NSQ_W-1:0]   nsq_r;
  logic [LEN_W-1:0]   root_r;
  logic [NSQ_W+1:0]   rrem_r;            // root remainder
  logic [65:0]        num_r;
  logic [LEN_W:0]     qrem_r;
  logic [ASPECT_W-1:0] q_r;
  logic               sat_r;
  logic [SUM_W-1:0]   sum_r;
  logic [TAL_W-1:0]   tally_r;
  logic               mean_last_r;
  res_t               res_r;
  logic               ovalid_r;

  tam_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  // Magnitude of the cross term being squared, split into 25-bit halves.
  logic [CROSS_W-1:0] nmag;
  logic [1:0]         nsel;
  logic signed [25:0] nhi, nlo;
  always_comb begin
    case (step_r) inside
      [5'd19:5'd21]: nsel = 2'd1;
      [5'd22:5'd24]: nsel = 2'd2;
      default:       nsel = 2'd0;
    endcase
    nmag = n_r[nsel][CROSS_W-1] ? CROSS_W'(-n_r[nsel]) : CROSS_W'(n_r[nsel]);
    nhi  = 26'(nmag[CROSS_W-1:25]);
    nlo  = 26'(nmag[24:0]);
  end

  // Multiply schedule: steps 0..8 squares of u,v,w, then 6 cross partials,
  // then hi*hi, hi*lo, lo*lo of each cross-term magnitude (steps 16..24);
  // step s issues, and its product is registered and collected at step s+1.
  always_comb begin
    ma = '0;
    mb = '0;
    if (step_r < 5'd9) begin
      ma = 26'(d_r[4'(step_r)]);
      mb = 26'(d_r[4'(step_r)]);
    end else begin
      case (step_r) inside
        5'd9:  begin ma = 26'(d_r[1]); mb = 26'(d_r[5]); end // uy*vz
        5'd10: begin ma = 26'(d_r[2]); mb = 26'(d_r[4]); end // uz*vy
        5'd11: begin ma = 26'(d_r[2]); mb = 26'(d_r[3]); end // uz*vx
        5'd12: begin ma = 26'(d_r[0]); mb = 26'(d_r[5]); end // ux*vz
        5'd13: begin ma = 26'(d_r[0]); mb = 26'(d_r[4]); end // ux*vy
        5'd14: begin ma = 26'(d_r[1]); mb = 26'(d_r[3]); end // uy*vx
        5'd16, 5'd19, 5'd22: begin ma = nhi; mb = nhi; end
        5'd17, 5'd20, 5'd23: begin ma = nhi; mb = nlo; end
        5'd18, 5'd21, 5'd24: begin ma = nlo; mb = nlo; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  // Edge sum that the square collected at this step belongs to.
  logic [1:0] eidx;
  always_comb begin
    case (step_r) inside
      [5'd4:5'd6]: eidx = 2'd1;
      [5'd7:5'd9]: eidx = 2'd2;
      default:     eidx = 2'd0;
    endcase
  end

  // Weight the collected half-width partial: hi*hi by 2^50, hi*lo twice by 2^25.
  logic [NSQ_W-1:0] nsq_term;
  always_comb begin
    case (step_r) inside
      5'd17, 5'd20, 5'd23: nsq_term = NSQ_W'(unsigned'(prod)) << 50;
      5'd18, 5'd21, 5'd24: nsq_term = NSQ_W'(unsigned'(prod)) << 26;
      default:             nsq_term = NSQ_W'(unsigned'(prod));
    endcase
  end

  // Root step: test bit b of the root via remainder recurrence.
  logic [NSQ_W+1:0] rtrial;
  logic [NSQ_W+1:0] rrem_sh;
  logic [6:0]       rb2;
  always_comb begin
    rb2     = 7'(bit_r) << 1;
    rrem_sh = (rrem_r << 2) | (NSQ_W+2)'(nsq_r[7'(rb2 + 7'd1)]  ) << 1
              | (NSQ_W+2)'(nsq_r[rb2]);
    rtrial  = {(NSQ_W+2-LEN_W-2)'(0), root_r, 2'b01};
  end

  // Aspect divide step.
  logic [LEN_W+1:0] qsh;
  logic             qge;
  always_comb begin
    qsh = {qrem_r, num_r[65]};
    qge = (root_r != '0) && (qsh >= (LEN_W+2)'(root_r));
  end

  // Mean divide step.
  logic [SUM_W:0]   msh;
  logic             mge;
  logic [SUM_W-1:0] mnum_r;
  logic [SUM_W-1:0] mq_r;
  logic [SUM_W-1:0] mrem_r;
  logic [MIDX_W-1:0] mcnt_r;
  always_comb begin
    msh = {mrem_r, mnum_r[SUM_W-1]};
    mge = msh >= (SUM_W+1)'(tally_r);
  end

  logic [EDGE_W-1:0] emax;
  always_comb begin
    emax = e_r[0];
    if (e_r[2] > emax) emax = e_r[2];
    if (e_r[1] > emax) emax = e_r[1];
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sum_r    <= '0;
      tally_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      // Drop the taken result; the output state reloads it itself.
      if (ovalid_r && out_ch.ready && state_r != ST_OUT) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            tri_r <= in_ch.data;
            if (in_ch.data.face_valid) state_r <= ST_DIFF;
            else if (in_ch.data.last_face) state_r <= ST_ACC;
          end
          mean_last_r <= in_ch.data.last_face;
        end
        ST_DIFF: begin
          d_r[0] <= DIFF_W'($signed(tri_r.bx)) - DIFF_W'($signed(tri_r.ax));
          d_r[1] <= DIFF_W'($signed(tri_r.by_coord)) - DIFF_W'($signed(tri_r.ay));
          d_r[2] <= DIFF_W'($signed(tri_r.bz)) - DIFF_W'($signed(tri_r.az));
          d_r[3] <= DIFF_W'($signed(tri_r.cx)) - DIFF_W'($signed(tri_r.ax));
          d_r[4] <= DIFF_W'($signed(tri_r.cy)) - DIFF_W'($signed(tri_r.ay));
          d_r[5] <= DIFF_W'($signed(tri_r.cz)) - DIFF_W'($signed(tri_r.az));
          d_r[6] <= DIFF_W'($signed(tri_r.cx)) - DIFF_W'($signed(tri_r.bx));
          d_r[7] <= DIFF_W'($signed(tri_r.cy)) - DIFF_W'($signed(tri_r.by_coord));
          d_r[8] <= DIFF_W'($signed(tri_r.cz)) - DIFF_W'($signed(tri_r.bz));
          e_r[0] <= '0; e_r[1] <= '0; e_r[2] <= '0;
          nsq_r  <= '0;
          step_r <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          // Collect product of step-1.
          step_r <= step_r + 5'd1;
          if (step_r >= 5'd1 && step_r <= 5'd9) begin
            e_r[eidx] <= e_r[eidx] + EDGE_W'(unsigned'(prod));
          end else if (step_r == 5'd10 || step_r == 5'd12 || step_r == 5'd14) begin
            part_r <= CROSS_W'(prod);
          end else if (step_r == 5'd11 || step_r == 5'd13 || step_r == 5'd15) begin
            n_r[2'((step_r - 5'd11) >> 1)] <= part_r - CROSS_W'(prod);
          end else if (step_r >= 5'd17 && step_r <= 5'd25) begin
            // Sum the weighted half-width partials of the squared cross terms.
            nsq_r <= nsq_r + nsq_term;
          end
          if (step_r == 5'd25) begin
            bit_r   <= 7'd50;
            root_r  <= '0;
            rrem_r  <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rrem_sh >= rtrial) begin
            rrem_r <= rrem_sh - rtrial;
            root_r <= {root_r[LEN_W-2:0], 1'b1};
          end else begin
            rrem_r <= rrem_sh;
            root_r <= {root_r[LEN_W-2:0], 1'b0};
          end
          if (bit_r == 7'd0) begin
            // Dividend is the largest squared edge scaled by 2^16; it stays below 2^66.
            num_r  <= {emax[49:0], 16'd0};
            qrem_r <= '0;
            q_r    <= '0;
            sat_r  <= 1'b0;
            bit_r  <= 7'd65;
            state_r <= ST_ADIV;
          end else begin
            bit_r <= bit_r - 7'd1;
          end
        end
        ST_ADIV: begin
          num_r <= {num_r[64:0], 1'b0};
          if (qge) begin
            qrem_r <= (LEN_W+1)'(qsh - (LEN_W+2)'(root_r));
            if (bit_r >= 7'd32) sat_r <= 1'b1;
            else q_r <= {q_r[ASPECT_W-2:0], 1'b1};
          end else begin
            qrem_r <= qsh[LEN_W:0];
            if (bit_r < 7'd32) q_r <= {q_r[ASPECT_W-2:0], 1'b0};
          end
          if (bit_r == 7'd0) state_r <= ST_ACC;
          else bit_r <= bit_r - 7'd1;
        end
        ST_ACC: begin
          if (tri_r.face_valid &&
              {1'b0, root_r} >= {thresh_r, 1'b0} >> 0 &&
              tally_r < TAL_W'(1) << FACE_COUNT_BITS) begin
            sum_r   <= sum_r + SUM_W'((root_r == '0 || sat_r) ? ASPECT_MAX : q_r);
            tally_r <= tally_r + TAL_W'(1);
          end
          state_r <= mean_last_r ? ST_MDIV : ST_IDLE;
          mcnt_r  <= '0;
        end
        ST_MDIV: begin
          if (mcnt_r == '0) begin
            mnum_r <= sum_r;
            mrem_r <= '0;
            mq_r   <= '0;
            mcnt_r <= MIDX_W'(1);
          end else begin
            mnum_r <= {mnum_r[SUM_W-2:0], 1'b0};
            mrem_r <= mge ? SUM_W'(msh - (SUM_W+1)'(tally_r)) : msh[SUM_W-1:0];
            mq_r   <= {mq_r[SUM_W-2:0], mge};
            mcnt_r <= mcnt_r + MIDX_W'(1);
            if (mcnt_r == MIDX_W'(SUM_W)) state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ovalid_r || out_ch.ready) begin
            res_r.mean_aspect   <= (tally_r == '0) ? '0 : mq_r[ASPECT_W-1:0];
            res_r.counted_faces <= COUNT_W'(tally_r);
            ovalid_r <= 1'b1;
            sum_r    <= '0;
            tally_r  <= '0;
            state_r  <= ST_IDLE;
          end
        end
        ST_HOLD: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/tam_checker.sv]
// Checker: port-level assertions for the triangle aspect mean unit.
`timescale 1ns / 1ps
`default_nettype none
module tam_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_face_valid,
  input wire logic in_last_face,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] mean_aspect,
  input wire logic [20:0] counted_faces
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mean_aspect))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_face_valid || in_last_face) |=> !in_ready)
    else $error("accepted while busy");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && counted_faces == 21'd0 |-> mean_aspect == 32'd0)
    else $error("nonzero mean with no faces");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind triangle_aspect_mean_unit tam_checker u_tam_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_face_valid(in_ch.data.face_valid), .in_last_face(in_ch.data.last_face),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .mean_aspect(out_ch.data.mean_aspect),
  .counted_faces(out_ch.data.counted_faces)
);
`default_nettype wire
